// ----- rtl/pn3_pkg.sv -----
// Shared types, constants, tables and helper functions for the 3D noise unit.
package pn3_pkg;

  localparam int TABLE_SIZE    = 256;
  localparam int IDX_W         = $clog2(TABLE_SIZE);
  localparam int Q_BITS        = 16;
  localparam int DEF_FRAC_BITS = 16;
  localparam int COORD_W       = 32;
  localparam int NOISE_W       = 16;
  localparam int FADE_W        = Q_BITS + 1;   // 0..1.0 inclusive
  localparam int VAL_W         = 20;           // gradient and lerp values
  localparam int DIF_W         = VAL_W + 1;    // lerp differences
  localparam int PRD_W         = FADE_W + 1 + DIF_W;
  localparam int NUM_CORNERS   = 8;
  localparam int NUM_LERP_X    = 4;

  localparam logic signed [VAL_W-1:0] Q_ONE_V = VAL_W'(65536);

  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic signed [VAL_W-1:0]  val_t;
  typedef logic signed [DIF_W-1:0]  dif_t;
  typedef logic signed [PRD_W-1:0]  prd_t;
  typedef logic [FADE_W-1:0]        fade_t;

  typedef enum logic {
    FUNC_QUERY = 1'b0,
    FUNC_WRITE = 1'b1
  } func_t;

  // Per-stage control carried along the pipe
  typedef struct packed {
    logic vld;
    logic wr;
  } ctl_t;

  // Table write request seen by one group of table copies
  typedef struct packed {
    logic we;
    idx_t addr;
    idx_t data;
  } tbl_wr_t;

  localparam logic [7:0] CLASSIC_PERM [TABLE_SIZE] = '{
    8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
    8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
    8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
    8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
    8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
    8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
    8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
    8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
    8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
    8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
    8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
    8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
    8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
    8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
    8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
    8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
    8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
    8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
    8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
    8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
    8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
    8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
    8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
    8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
    8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
    8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
    8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
    8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
    8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
    8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
    8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
    8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
  };

  // Floor of a Q.16 product back to a Q.16 value
  function automatic val_t floor_q(input prd_t p);
    prd_t s;
    s = p >>> Q_BITS;
    return s[VAL_W-1:0];
  endfunction

  // Fade weight (0..1.0) times a signed difference
  function automatic prd_t mul_w(input fade_t t, input dif_t d);
    logic signed [FADE_W:0] ts;
    ts = $signed({1'b0, t});
    return PRD_W'(ts * d);
  endfunction

  // 12-direction gradient dot product, selected by the low hash nibble
  function automatic val_t grad(input idx_t hash, input val_t x, input val_t y,
                                input val_t z);
    logic [3:0] h;
    val_t u;
    val_t v;
    h = hash[3:0];
    u = (h < 4'd8) ? x : y;
    v = (h < 4'd4) ? y : (((h == 4'd12) || (h == 4'd14)) ? x : z);
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

endpackage

// ----- rtl/pn3_if.sv -----
// Valid/ready channel interfaces for queries and noise results.
interface pn3_in_if import pn3_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      func;
  logic signed [COORD_W-1:0] coord_x;
  logic signed [COORD_W-1:0] coord_y;
  logic signed [COORD_W-1:0] coord_z;
  logic [IDX_W-1:0]          entry_index;
  logic [IDX_W-1:0]          entry_value;

  modport source (output valid, func, coord_x, coord_y, coord_z, entry_index,
                  entry_value, input ready);
  modport sink (input valid, func, coord_x, coord_y, coord_z, entry_index,
                entry_value, output ready);
endinterface

interface pn3_out_if import pn3_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [NOISE_W-1:0] noise;

  modport source (output valid, noise, input ready);
  modport sink (input valid, noise, output ready);
endinterface

// ----- rtl/pn3_perm_bank.sv -----
// One copy of the permutation table: one write port, two registered read ports.
module pn3_perm_bank import pn3_pkg::*; (
  input  logic    clk,
  input  logic    en,
  input  logic    init,
  input  idx_t    init_addr,
  input  tbl_wr_t wr,
  input  idx_t    raddr [2],
  output idx_t    rdata [2]
);

  idx_t mem [TABLE_SIZE];
  idx_t rd_r [2];

  // Storage and registered reads; the clearing pass loads the classic permutation
  always_ff @(posedge clk) begin
    if (init) begin
      mem[init_addr] <= CLASSIC_PERM[init_addr];
    end else if (en && wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    if (en) begin
      for (int p = 0; p < 2; p++) begin
        rd_r[p] <= mem[raddr[p]];
      end
    end
  end

  always_comb begin
    for (int p = 0; p < 2; p++) begin
      rdata[p] = rd_r[p];
    end
  end

endmodule

// ----- rtl/pn3_hash.sv -----
// Three-level corner hash; each level reads its own table copies.
module pn3_hash import pn3_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    en,
  input  logic    init,
  input  idx_t    init_addr,
  input  tbl_wr_t wr_i,
  input  idx_t    cell_x,
  input  idx_t    cell_y,
  input  idx_t    cell_z,
  output idx_t    hash_o [NUM_CORNERS]
);

  tbl_wr_t wr2_r;
  tbl_wr_t wr3_r;
  idx_t    cy2_r;
  idx_t    cz2_r;
  idx_t    cz3_r;

  idx_t a_raddr [2];
  idx_t a_rdata [2];
  idx_t b_raddr [2][2];
  idx_t b_rdata [2][2];
  idx_t c_raddr [4][2];
  idx_t c_rdata [4][2];
  idx_t row_a;
  idx_t row_b;
  idx_t base_c [4];

  // Writes follow the items so every query sees the table of its turn
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr2_r.we <= 1'b0;
      wr3_r.we <= 1'b0;
    end else if (en) begin
      wr2_r.we <= wr_i.we;
      wr3_r.we <= wr2_r.we;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wr2_r.addr <= wr_i.addr;
      wr2_r.data <= wr_i.data;
      wr3_r.addr <= wr2_r.addr;
      wr3_r.data <= wr2_r.data;
      cy2_r      <= cell_y;
      cz2_r      <= cell_z;
      cz3_r      <= cz2_r;
    end
  end

  // Level 1: perm[x], perm[x+1]
  assign a_raddr[0] = cell_x;
  assign a_raddr[1] = cell_x + idx_t'(1);

  pn3_perm_bank u_bank_a (
    .clk       (clk),
    .en        (en),
    .init      (init),
    .init_addr (init_addr),
    .wr        (wr_i),
    .raddr     (a_raddr),
    .rdata     (a_rdata)
  );

  // Level 2: rows a and b plus their neighbors
  assign row_a = a_rdata[0] + cy2_r;
  assign row_b = a_rdata[1] + cy2_r;
  assign b_raddr[0][0] = row_a;
  assign b_raddr[0][1] = row_a + idx_t'(1);
  assign b_raddr[1][0] = row_b;
  assign b_raddr[1][1] = row_b + idx_t'(1);

  for (genvar g = 0; g < 2; g++) begin : g_bank_b
    pn3_perm_bank u_bank (
      .clk       (clk),
      .en        (en),
      .init      (init),
      .init_addr (init_addr),
      .wr        (wr2_r),
      .raddr     (b_raddr[g]),
      .rdata     (b_rdata[g])
    );
  end

  // Level 3: aa, ab, ba, bb and each one's z+1 neighbor
  assign base_c[0] = b_rdata[0][0] + cz3_r;
  assign base_c[1] = b_rdata[0][1] + cz3_r;
  assign base_c[2] = b_rdata[1][0] + cz3_r;
  assign base_c[3] = b_rdata[1][1] + cz3_r;

  for (genvar g = 0; g < 4; g++) begin : g_bank_c
    assign c_raddr[g][0] = base_c[g];
    assign c_raddr[g][1] = base_c[g] + idx_t'(1);

    pn3_perm_bank u_bank (
      .clk       (clk),
      .en        (en),
      .init      (init),
      .init_addr (init_addr),
      .wr        (wr3_r),
      .raddr     (c_raddr[g]),
      .rdata     (c_rdata[g])
    );

    assign hash_o[2*g]   = c_rdata[g][0];
    assign hash_o[2*g+1] = c_rdata[g][1];
  end

endmodule

// ----- rtl/pn3_fade.sv -----
// Three-stage fade curve 6t^5-15t^4+10t^3 on a Q0.16 fraction.
module pn3_fade import pn3_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [Q_BITS-1:0] t_i,
  output fade_t             f_o,
  output logic [Q_BITS-1:0] t_o
);

  logic signed [Q_BITS+4:0]   a_s1;
  logic signed [2*Q_BITS+5:0] ta_s1;
  logic [2*Q_BITS-1:0]        tt_s1;
  logic signed [Q_BITS+5:0]   ta_r;
  logic [Q_BITS-1:0]          t2_r;
  logic [Q_BITS-1:0]          t_s2_r;
  logic signed [Q_BITS+5:0]   b_s2;
  logic [2*Q_BITS-1:0]        p3_s2;
  logic signed [Q_BITS+5:0]   b_r;
  logic [Q_BITS-1:0]          t3_r;
  logic [Q_BITS-1:0]          t_s3_r;
  logic signed [2*Q_BITS+6:0] pf_s3;
  logic signed [Q_BITS+6:0]   fl_s3;
  fade_t                      f_s3;
  fade_t                      f_r;
  logic [Q_BITS-1:0]          t_s4_r;

  // Stage 1: a = 6t-15, t*a and t*t
  always_comb begin
    a_s1  = $signed({5'd0, t_i}) * (Q_BITS+5)'(6) - (Q_BITS+5)'(15 * 65536);
    ta_s1 = $signed({1'b0, t_i}) * a_s1;
    tt_s1 = t_i * t_i;
  end

  // Stage 2: b = floor(t*a)+10, t^3
  always_comb begin
    b_s2  = ta_r + (Q_BITS+6)'(10 * 65536);
    p3_s2 = t2_r * t_s2_r;
  end

  // Stage 3: floor(t^3*b), clamped to 0..1.0
  always_comb begin
    pf_s3 = $signed({1'b0, t3_r}) * b_r;
    fl_s3 = pf_s3[2*Q_BITS+6:Q_BITS];
    if (fl_s3 < 0) begin
      f_s3 = '0;
    end else if (fl_s3 > (Q_BITS+7)'(65536)) begin
      f_s3 = fade_t'(65536);
    end else begin
      f_s3 = fl_s3[FADE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ta_r   <= ta_s1[2*Q_BITS+5:Q_BITS];
      t2_r   <= tt_s1[2*Q_BITS-1:Q_BITS];
      t_s2_r <= t_i;
      b_r    <= b_s2;
      t3_r   <= p3_s2[2*Q_BITS-1:Q_BITS];
      t_s3_r <= t_s2_r;
      f_r    <= f_s3;
      t_s4_r <= t_s3_r;
    end
  end

  assign f_o = f_r;
  assign t_o = t_s4_r;

endmodule

// ----- rtl/pn3_blend.sv -----
// Gradient dot products and trilinear blend, six register stages.
module pn3_blend import pn3_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  idx_t               hash_i [NUM_CORNERS],
  input  logic [Q_BITS-1:0]  fx_i,
  input  logic [Q_BITS-1:0]  fy_i,
  input  logic [Q_BITS-1:0]  fz_i,
  input  fade_t              u_i,
  input  fade_t              v_i,
  input  fade_t              w_i,
  output logic [NOISE_W-1:0] noise_o
);

  val_t  x0, x1, y0, y1, z0, z1;
  val_t  glo_s4 [NUM_LERP_X];
  val_t  ghi_s4 [NUM_LERP_X];
  val_t  base5_r [NUM_LERP_X];
  dif_t  dx5_r [NUM_LERP_X];
  prd_t  px6_r [NUM_LERP_X];
  val_t  base6_r [NUM_LERP_X];
  val_t  l_s7 [NUM_LERP_X];
  val_t  lo7_r [2];
  dif_t  dv7_r [2];
  prd_t  pv8_r [2];
  val_t  lo8_r [2];
  val_t  m0_s9;
  val_t  m1_s9;
  val_t  m9_r;
  dif_t  dw9_r;
  prd_t  pw10_r;
  val_t  m10_r;
  fade_t u5_r;
  fade_t v5_r, v6_r, v7_r;
  fade_t w5_r, w6_r, w7_r, w8_r, w9_r;
  val_t  n_s11;
  logic signed [VAL_W:0] r_s11;

  // Corner offsets t and t-1
  always_comb begin
    x0 = val_t'({4'd0, fx_i});
    y0 = val_t'({4'd0, fy_i});
    z0 = val_t'({4'd0, fz_i});
    x1 = x0 - Q_ONE_V;
    y1 = y0 - Q_ONE_V;
    z1 = z0 - Q_ONE_V;
  end

  // Gradients of the four x-edges: (aa,ba) (ab,bb) (aa+1,ba+1) (ab+1,bb+1)
  always_comb begin
    glo_s4[0] = grad(hash_i[0], x0, y0, z0);
    ghi_s4[0] = grad(hash_i[4], x1, y0, z0);
    glo_s4[1] = grad(hash_i[2], x0, y1, z0);
    ghi_s4[1] = grad(hash_i[6], x1, y1, z0);
    glo_s4[2] = grad(hash_i[1], x0, y0, z1);
    ghi_s4[2] = grad(hash_i[5], x1, y0, z1);
    glo_s4[3] = grad(hash_i[3], x0, y1, z1);
    ghi_s4[3] = grad(hash_i[7], x1, y1, z1);
  end

  // Edge lerp results along x
  always_comb begin
    for (int i = 0; i < NUM_LERP_X; i++) begin
      l_s7[i] = base6_r[i] + floor_q(px6_r[i]);
    end
  end

  assign m0_s9 = lo8_r[0] + floor_q(pv8_r[0]);
  assign m1_s9 = lo8_r[1] + floor_q(pv8_r[1]);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NUM_LERP_X; i++) begin
        // stage 5: differences
        base5_r[i] <= glo_s4[i];
        dx5_r[i]   <= dif_t'(ghi_s4[i]) - dif_t'(glo_s4[i]);
        // stage 6: products along x
        px6_r[i]   <= mul_w(u5_r, dx5_r[i]);
        base6_r[i] <= base5_r[i];
      end
      u5_r <= u_i;
      v5_r <= v_i;
      v6_r <= v5_r;
      v7_r <= v6_r;
      w5_r <= w_i;
      w6_r <= w5_r;
      w7_r <= w6_r;
      w8_r <= w7_r;
      w9_r <= w8_r;
      // stage 7: y differences
      lo7_r[0] <= l_s7[0];
      lo7_r[1] <= l_s7[2];
      dv7_r[0] <= dif_t'(l_s7[1]) - dif_t'(l_s7[0]);
      dv7_r[1] <= dif_t'(l_s7[3]) - dif_t'(l_s7[2]);
      // stage 8: products along y
      for (int j = 0; j < 2; j++) begin
        pv8_r[j] <= mul_w(v7_r, dv7_r[j]);
        lo8_r[j] <= lo7_r[j];
      end
      // stage 9: z difference
      m9_r  <= m0_s9;
      dw9_r <= dif_t'(m1_s9) - dif_t'(m0_s9);
      // stage 10: product along z
      pw10_r <= mul_w(w9_r, dw9_r);
      m10_r  <= m9_r;
    end
  end

  // (n+1)/2, saturated to unsigned Q0.16
  always_comb begin
    n_s11 = m10_r + floor_q(pw10_r);
    r_s11 = (VAL_W+1)'(n_s11) + (VAL_W+1)'(65536);
    if (r_s11 < 0) begin
      noise_o = '0;
    end else if (r_s11[VAL_W:1] > (VAL_W)'(65535)) begin
      noise_o = '1;
    end else begin
      noise_o = r_s11[NOISE_W:1];
    end
  end

endmodule

// ----- rtl/perlin_noise_3d_unit.sv -----
// Top level of the pipelined 3D improved-noise unit.
//
// Channels: in_ch takes items; func selects a noise query or a write of one
// permutation table entry (entry_index, entry_value). out_ch returns one
// 16-bit noise value per query, in query order; writes return nothing.
// Coordinates are signed fixed point with FRAC_BITS fraction bits; the low
// 8 bits of each floor pick the lattice cell.
// A query goes through the input register, the hash and fade stages, the
// blend stages and the output register to out_ch. Throughput: one item per
// clock when nothing stalls. Three stages read seven copies of the table
// (one, two and four dual-read copies); a write updates each copy as it
// passes that copy's stage, so queries before and after it see the old and
// new table exactly. Reset: the pipe empties, then a clearing pass loads the
// classic permutation into every copy, entry by entry; in_ch.ready stays low
// during reset and for the whole pass.
// Stall: while out_ch holds an untaken result the whole pipe freezes and
// in_ch.ready is low; nothing is dropped or repeated.
module perlin_noise_3d_unit import pn3_pkg::*; #(
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input logic        clk,
  input logic        rst_n,
  pn3_in_if.sink     in_ch,
  pn3_out_if.source  out_ch
);

  localparam int          LAST_STAGE = 10;
  localparam int          SH_R  = (FRAC_BITS >= Q_BITS) ? FRAC_BITS - Q_BITS : 0;
  localparam int          SH_L  = (FRAC_BITS < Q_BITS) ? Q_BITS - FRAC_BITS : 0;
  localparam logic [COORD_W-1:0] FMASK = COORD_W'((64'd1 << FRAC_BITS) - 64'd1);

  logic               adv;
  logic               init_r;
  idx_t               init_addr_r;
  ctl_t               ctl_r [1:LAST_STAGE];
  idx_t               cx1_r, cy1_r, cz1_r;
  logic [Q_BITS-1:0]  fx1_r, fy1_r, fz1_r;
  idx_t               widx1_r, wval1_r;
  logic [COORD_W-1:0] fx_full, fy_full, fz_full;
  tbl_wr_t            wr1;
  idx_t               hash4 [NUM_CORNERS];
  fade_t              u4, v4, w4;
  logic [Q_BITS-1:0]  fx4, fy4, fz4;
  logic [NOISE_W-1:0] noise10;
  logic               out_valid_r;
  logic [NOISE_W-1:0] out_noise_r;

  // Whole pipe moves unless a result waits at the output
  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv && !init_r;

  // Clearing pass after reset: one table entry per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r      <= 1'b1;
      init_addr_r <= '0;
    end else if (init_r) begin
      init_addr_r <= init_addr_r + idx_t'(1);
      if (init_addr_r == idx_t'(TABLE_SIZE - 1)) begin
        init_r <= 1'b0;
      end
    end
  end

  // Fractions brought to Q0.16
  always_comb begin
    fx_full = ((COORD_W'(in_ch.coord_x) & FMASK) >> SH_R) << SH_L;
    fy_full = ((COORD_W'(in_ch.coord_y) & FMASK) >> SH_R) << SH_L;
    fz_full = ((COORD_W'(in_ch.coord_z) & FMASK) >> SH_R) << SH_L;
  end

  // Control pipe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 1; i <= LAST_STAGE; i++) begin
        ctl_r[i] <= '0;
      end
    end else if (adv) begin
      ctl_r[1].vld <= in_ch.valid && !init_r;
      ctl_r[1].wr  <= (func_t'(in_ch.func) == FUNC_WRITE);
      for (int i = 2; i <= LAST_STAGE; i++) begin
        ctl_r[i] <= ctl_r[i-1];
      end
    end
  end

  // Input stage
  always_ff @(posedge clk) begin
    if (adv) begin
      cx1_r   <= IDX_W'(in_ch.coord_x >>> FRAC_BITS);
      cy1_r   <= IDX_W'(in_ch.coord_y >>> FRAC_BITS);
      cz1_r   <= IDX_W'(in_ch.coord_z >>> FRAC_BITS);
      fx1_r   <= fx_full[Q_BITS-1:0];
      fy1_r   <= fy_full[Q_BITS-1:0];
      fz1_r   <= fz_full[Q_BITS-1:0];
      widx1_r <= in_ch.entry_index;
      wval1_r <= in_ch.entry_value;
    end
  end

  assign wr1.we   = ctl_r[1].vld && ctl_r[1].wr;
  assign wr1.addr = widx1_r;
  assign wr1.data = wval1_r;

  pn3_hash u_hash (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .init      (init_r),
    .init_addr (init_addr_r),
    .wr_i      (wr1),
    .cell_x    (cx1_r),
    .cell_y    (cy1_r),
    .cell_z    (cz1_r),
    .hash_o    (hash4)
  );

  pn3_fade u_fade_x (.clk(clk), .en(adv), .t_i(fx1_r), .f_o(u4), .t_o(fx4));
  pn3_fade u_fade_y (.clk(clk), .en(adv), .t_i(fy1_r), .f_o(v4), .t_o(fy4));
  pn3_fade u_fade_z (.clk(clk), .en(adv), .t_i(fz1_r), .f_o(w4), .t_o(fz4));

  pn3_blend u_blend (
    .clk     (clk),
    .en      (adv),
    .hash_i  (hash4),
    .fx_i    (fx4),
    .fy_i    (fy4),
    .fz_i    (fz4),
    .u_i     (u4),
    .v_i     (v4),
    .w_i     (w4),
    .noise_o (noise10)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= ctl_r[LAST_STAGE].vld && !ctl_r[LAST_STAGE].wr;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_noise_r <= noise10;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.noise = out_noise_r;

endmodule

// ----- rtl/pn3_checker.sv -----
// Port-level checks for the noise unit, bound to the top level.
module pn3_checker import pn3_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [NOISE_W-1:0] out_noise
);

  // A waiting result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A waiting result keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_noise))
    else $error("result changed while stalled");

  // The pipe freezes as a whole: no input transfer while the output waits
  a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  // Reset empties the pipe
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result shown right after reset");

  // Once the table is loaded, input is taken whenever the output is free
  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && $past(in_ready) && $past(rst_n) |-> in_ready)
    else $error("input blocked with empty output");

endmodule

bind perlin_noise_3d_unit pn3_checker u_pn3_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_noise (out_ch.noise)
);
